[rtl/aeng_pkg.sv]
// shared types and constants of the adaptive ema noise gate
`timescale 1ns / 1ps
`default_nettype none

package aeng_pkg;

	localparam int SampleW = 16;
	localparam int CoefW   = 16;
	localparam int WetW    = 17;
	localparam int StateW  = 24;
	localparam int OpAW    = 18;
	localparam int OpBW    = 25;
	localparam int AccW    = 42;
	localparam int StepW   = 3;
	localparam int CfgIdxW = 3;

	localparam logic [StepW-1:0] LastStep = 3'd7;

	localparam logic [CfgIdxW-1:0] RegEnvCoef  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegAlphaMin = 3'd1;
	localparam logic [CfgIdxW-1:0] RegAlphaMax = 3'd2;
	localparam logic [CfgIdxW-1:0] RegGateThr  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegWetMix   = 3'd4;

	localparam logic [CoefW-1:0] EnvCoefRst  = 16'd655;
	localparam logic [CoefW-1:0] AlphaMinRst = 16'd66;
	localparam logic [CoefW-1:0] AlphaMaxRst = 16'd32768;
	localparam logic [CoefW-1:0] GateThrRst  = 16'd328;
	localparam logic [WetW-1:0]  WetMixRst   = 17'd65536;

	localparam logic [OpAW-1:0]   OneQ16  = 18'h10000;
	localparam logic [OpBW-1:0]   OneQ23  = 25'h0800000;
	localparam logic [WetW-1:0]   WetFull = 17'h10000;

	// rounding offsets preloaded at the first step of each product pair
	localparam logic signed [AccW-1:0] HalfQ16 = 42'sd32768;
	localparam logic signed [AccW-1:0] HalfQ23 = 42'sd4194304;
	localparam logic signed [AccW-1:0] HalfQ24 = 42'sd8388608;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

endpackage

`default_nettype wire

[rtl/adaptive_ema_noise_gate.sv]
// adaptive ema noise gate: envelope, adaptive one-pole low-pass and wet/dry mix
// after accept: 8 mac steps in ST_CALC, then the output register is loaded in ST_HOLD
// a request with input_missing set skips ST_CALC and goes straight to ST_HOLD
// new requests wait for ST_IDLE: the single shared 18x25 multiply-accumulate does every step
// reset: arst_n asynchronous active low, clears envelope, filter state, registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module adaptive_ema_noise_gate (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [aeng_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [aeng_pkg::WetW-1:0]         cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [15:0]                       s_axis_tdata,  // [15:0] audio_in
	input  wire logic                              s_axis_tuser,  // [0] input_missing
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [31:0]                            m_axis_tdata   // [15:0] left_out, [31:16] right_out
);

	aeng_pkg::state_t state_q;
	logic [aeng_pkg::StepW-1:0] step_q;

	logic [aeng_pkg::CoefW-1:0] env_coef_q;
	logic [aeng_pkg::CoefW-1:0] alpha_min_q;
	logic [aeng_pkg::CoefW-1:0] alpha_max_q;
	logic [aeng_pkg::CoefW-1:0] gate_thr_q;
	logic [aeng_pkg::WetW-1:0]  wet_mix_q;

	logic [aeng_pkg::StateW-1:0]        env_q;
	logic signed [aeng_pkg::StateW-1:0] fv_q;

	logic signed [aeng_pkg::SampleW-1:0] x_q;
	logic [aeng_pkg::StateW-1:0]         mag_q;
	logic signed [aeng_pkg::StateW-1:0]  g_q;
	logic [aeng_pkg::CoefW-1:0]          alpha_q;
	logic signed [aeng_pkg::SampleW-1:0] y_q;
	logic signed [aeng_pkg::AccW-1:0]    acc_q;

	logic                                out_valid_q;
	logic [31:0]                         out_data_q;

	logic [aeng_pkg::WetW-1:0]           wet_w;
	logic signed [aeng_pkg::OpAW-1:0]    op_a;
	logic signed [aeng_pkg::OpBW-1:0]    op_b;
	logic signed [aeng_pkg::OpAW+aeng_pkg::OpBW-1:0] prod;
	logic signed [aeng_pkg::AccW-1:0]    acc_in;
	logic signed [aeng_pkg::AccW-1:0]    sum;
	logic [aeng_pkg::StateW:0]           abs_in;
	logic signed [25:0]                  f_sh;
	logic signed [17:0]                  y_sh;
	logic [aeng_pkg::StateW-1:0]         env_new;
	logic [aeng_pkg::CoefW-1:0]          alpha_new;
	logic signed [aeng_pkg::StateW-1:0]  f_new;
	logic signed [aeng_pkg::SampleW-1:0] y_new;
	logic                                in_acc;
	logic                                out_load;

	assign s_axis_tready = (state_q == aeng_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == aeng_pkg::ST_HOLD) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign wet_w  = (wet_mix_q > aeng_pkg::WetFull) ? aeng_pkg::WetFull : wet_mix_q;
	assign abs_in = s_axis_tdata[15] ? 25'({1'b0, ~s_axis_tdata} + 17'd1) << 8
	                                 : 25'({1'b0, s_axis_tdata}) << 8;

	// operand selection for the shared multiply-accumulate
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		acc_in = acc_q;
		case (step_q)
			3'd0: begin
				op_a   = $signed({2'b00, env_coef_q});
				op_b   = $signed({1'b0, mag_q});
				acc_in = aeng_pkg::HalfQ16;
			end
			3'd1: begin
				op_a = $signed(aeng_pkg::OneQ16 - {2'b00, env_coef_q});
				op_b = $signed({1'b0, env_q});
			end
			3'd2: begin
				op_a   = $signed({2'b00, alpha_min_q});
				op_b   = $signed(aeng_pkg::OneQ23 - {1'b0, env_q});
				acc_in = aeng_pkg::HalfQ23;
			end
			3'd3: begin
				op_a = $signed({2'b00, alpha_max_q});
				op_b = $signed({1'b0, env_q});
			end
			3'd4: begin
				op_a   = $signed({2'b00, alpha_q});
				op_b   = {g_q[23], g_q};
				acc_in = aeng_pkg::HalfQ16;
			end
			3'd5: begin
				op_a = $signed(aeng_pkg::OneQ16 - {2'b00, alpha_q});
				op_b = {fv_q[23], fv_q};
			end
			3'd6: begin
				op_a   = $signed({1'b0, wet_w});
				op_b   = {fv_q[23], fv_q};
				acc_in = aeng_pkg::HalfQ24;
			end
			3'd7: begin
				op_a = $signed(aeng_pkg::OneQ16 - {1'b0, wet_w});
				op_b = {g_q[23], g_q};
			end
			default: begin
				op_a   = '0;
				op_b   = '0;
				acc_in = acc_q;
			end
		endcase
	end

	assign prod = op_a * op_b;
	assign sum  = acc_in + prod[aeng_pkg::AccW-1:0];

	// rounding shifts and saturation of the finished pairs
	always_comb begin
		f_sh = sum[41:16];
		y_sh = sum[41:24];
		env_new   = (sum[41:16] > 26'h0800000) ? 24'h800000 : sum[39:16];
		alpha_new = (sum[41:23] > 19'h0ffff) ? 16'hffff : sum[38:23];
		if (f_sh > 26'sh07fffff) begin
			f_new = 24'sh7fffff;
		end else if (f_sh < -26'sh0800000) begin
			f_new = -24'sh800000;
		end else begin
			f_new = f_sh[23:0];
		end
		if (y_sh > 18'sh07fff) begin
			y_new = 16'sh7fff;
		end else if (y_sh < -18'sh08000) begin
			y_new = -16'sh8000;
		end else begin
			y_new = y_sh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_coef_q  <= aeng_pkg::EnvCoefRst;
			alpha_min_q <= aeng_pkg::AlphaMinRst;
			alpha_max_q <= aeng_pkg::AlphaMaxRst;
			gate_thr_q  <= aeng_pkg::GateThrRst;
			wet_mix_q   <= aeng_pkg::WetMixRst;
		end else if (cfg_wen) begin
			case (cfg_index)
				aeng_pkg::RegEnvCoef:  env_coef_q  <= cfg_data[15:0];
				aeng_pkg::RegAlphaMin: alpha_min_q <= cfg_data[15:0];
				aeng_pkg::RegAlphaMax: alpha_max_q <= cfg_data[15:0];
				aeng_pkg::RegGateThr:  gate_thr_q  <= cfg_data[15:0];
				aeng_pkg::RegWetMix:   wet_mix_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aeng_pkg::ST_IDLE;
			step_q      <= '0;
			env_q       <= '0;
			fv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				aeng_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= s_axis_tuser ? aeng_pkg::ST_HOLD : aeng_pkg::ST_CALC;
						step_q  <= '0;
					end
				end
				aeng_pkg::ST_CALC: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd1) begin
						env_q <= env_new;
					end
					if (step_q == 3'd5) begin
						fv_q <= f_new;
					end
					if (step_q == aeng_pkg::LastStep) begin
						state_q <= aeng_pkg::ST_HOLD;
					end
				end
				aeng_pkg::ST_HOLD: begin
					if (out_load) begin
						state_q <= aeng_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= aeng_pkg::ST_IDLE;
					step_q  <= '0;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q   <= $signed(s_axis_tdata);
			mag_q <= abs_in[23:0];
			y_q   <= '0;
		end
		if (state_q == aeng_pkg::ST_CALC) begin
			acc_q <= sum;
			if (step_q == 3'd2) begin
				g_q <= (env_q < {gate_thr_q, 8'h00}) ? '0 : {x_q, 8'h00};
			end
			if (step_q == 3'd3) begin
				alpha_q <= alpha_new;
			end
			if (step_q == aeng_pkg::LastStep) begin
				y_q <= y_new;
			end
		end
		if (out_load) begin
			out_data_q <= {y_q, y_q};
		end
	end

	a_missing_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser) |=> (state_q == aeng_pkg::ST_HOLD && y_q == '0))
		else $error("missing input did not give silence");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != aeng_pkg::ST_CALC) |-> (step_q == '0))
		else $error("step counter running outside calculation");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= 24'h800000)
		else $error("envelope above full scale");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aeng_pkg::ST_HOLD && out_valid_q && !m_axis_tready)
		|=> (state_q == aeng_pkg::ST_HOLD))
		else $error("result dropped while output stalled");

endmodule

`default_nettype wire

[tb/aeng_result_checker.sv]
// checker of the adaptive ema noise gate: tracks registers, predicts every request, compares outputs
`timescale 1ns / 1ps

module aeng_result_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [aeng_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [aeng_pkg::WetW-1:0]    cfg_data,
	input  wire logic                         s_axis_tvalid,
	input  wire logic                         s_axis_tready,
	input  wire logic [15:0]                  s_axis_tdata,  // [15:0] audio_in
	input  wire logic                         s_axis_tuser,  // [0] input_missing
	input  wire logic                         m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	input  wire logic [31:0]                  m_axis_tdata,  // [15:0] left_out, [31:16] right_out
	output int                                mismatches,
	output int                                outstanding
);
	import aeng_pkg::*;

	localparam longint UnitQ16 = 64'sd65536;
	localparam longint UnitQ23 = 64'sd8388608;

	typedef struct packed {
		logic [SampleW-1:0] right;
		logic [SampleW-1:0] left;
	} stereo_t;

	logic [CoefW-1:0] env_coef;
	logic [CoefW-1:0] alpha_lo;
	logic [CoefW-1:0] alpha_hi;
	logic [CoefW-1:0] gate_thr;
	logic [WetW-1:0]  wet;
	longint           env_level;
	longint           lp_state;
	stereo_t          stereo_due[$];
	int               miss_cnt;

	task automatic flag_mismatch(input string what);
		miss_cnt++;
		$display("%0t ns: mismatch, %s", $time, what);
	endtask

	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// envelope, adaptive alpha, gate, one-pole low-pass and wet/dry mix for one sample
	function automatic logic [SampleW-1:0] gate_and_filter(input logic signed [SampleW-1:0] smp);
		longint x;
		longint env;
		longint alpha;
		longint g;
		longint f;
		longint w;
		longint y;
		x = longint'(smp);
		env = (longint'(env_coef) * ((x < 0) ? -x : x) * 256
		       + (UnitQ16 - longint'(env_coef)) * env_level + 32768) >>> 16;
		env = clip(env, 0, UnitQ23);
		env_level = env;
		alpha = (longint'(alpha_lo) * (UnitQ23 - env) + longint'(alpha_hi) * env
		         + UnitQ23 / 2) >>> 23;
		alpha = clip(alpha, 0, 65535);
		g = (env < longint'(gate_thr) * 256) ? 0 : x * 256;
		f = clip(round_shift(alpha * g + (UnitQ16 - alpha) * lp_state, 16),
		         -UnitQ23, UnitQ23 - 1);
		lp_state = f;
		w = (wet > WetFull) ? UnitQ16 : longint'(wet);
		y = clip(round_shift(w * f + (UnitQ16 - w) * g, 24), -32768, 32767);
		return y[SampleW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stereo_t            got;
		stereo_t            want;
		logic [SampleW-1:0] y;
		if (!arst_n) begin
			env_coef = EnvCoefRst;
			alpha_lo = AlphaMinRst;
			alpha_hi = AlphaMaxRst;
			gate_thr = GateThrRst;
			wet = WetMixRst;
			env_level = 0;
			lp_state = 0;
			stereo_due.delete();
			miss_cnt = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (stereo_due.size() == 0) begin
					flag_mismatch($sformatf("output %h with no request pending", got));
				end else begin
					want = stereo_due.pop_front();
					if (got.left !== want.left)
						flag_mismatch($sformatf("left_out %h, predicted %h", got.left, want.left));
					if (got.right !== want.right)
						flag_mismatch($sformatf("right_out %h, predicted %h", got.right,
						                        want.right));
				end
			end
			if (cfg_wen) begin
				case (cfg_index)
					RegEnvCoef:  env_coef = cfg_data[CoefW-1:0];
					RegAlphaMin: alpha_lo = cfg_data[CoefW-1:0];
					RegAlphaMax: alpha_hi = cfg_data[CoefW-1:0];
					RegGateThr:  gate_thr = cfg_data[CoefW-1:0];
					RegWetMix:   wet = cfg_data;
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					y = '0;
				else
					y = gate_and_filter(s_axis_tdata);
				stereo_due.push_back({y, y});
			end
			outstanding <= stereo_due.size();
			mismatches <= miss_cnt;
		end
	end

endmodule

[tb/tb_adaptive_ema_noise_gate.sv]
// testbench top of the adaptive ema noise gate: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_adaptive_ema_noise_gate;
	import aeng_pkg::*;

	localparam int CycleLimit   = 400000;
	localparam int RxHoldCycles = 300;
	localparam int DrainCycles  = 20;
	localparam int PhaseItems   = 125;
	localparam int Phases       = 8;
	localparam int RunLength    = 16;
	localparam int MaxIdle      = 18;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [CfgIdxW-1:0] cfg_index;
	logic [WetW-1:0]    cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [15:0]        s_axis_tdata;
	logic               s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [31:0]        m_axis_tdata;
	int                 mismatches;
	int                 outstanding;
	int                 cycles;
	bit                 steady;
	bit                 rx_hold_req;

	adaptive_ema_noise_gate dut (.*);

	aeng_result_checker checker_i (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int idle_cycles();
		return steady ? 0 : $urandom_range(0, MaxIdle);
	endfunction

	function automatic logic [15:0] random_sample(input int amp);
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return 16'h8000;
		if (pick == 1)
			return 16'h7fff;
		return 16'($urandom_range(0, 2 * amp) - amp);
	endfunction

	function automatic logic [CoefW-1:0] pick_coef();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CoefW-1:0] pick_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'd32768;
			2: return '1;
			3: return 16'($urandom_range(0, 32768));
			default: return 16'($urandom_range(0, 2048));
		endcase
	endfunction

	function automatic logic [WetW-1:0] pick_wet();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return WetFull;
			2: return '1;
			3: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic send_request(input logic [15:0] smp, input logic miss);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= miss;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WetW-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// upper data bit is noise for the 16-bit registers; an unmapped index is written last
	task automatic apply_settings(input logic [CoefW-1:0] coef, input logic [CoefW-1:0] amin,
	                              input logic [CoefW-1:0] amax, input logic [CoefW-1:0] thr,
	                              input logic [WetW-1:0] wet);
		write_reg(RegEnvCoef, {1'($urandom), coef});
		write_reg(RegAlphaMin, {1'($urandom), amin});
		write_reg(RegAlphaMax, {1'($urandom), amax});
		write_reg(RegGateThr, {1'($urandom), thr});
		write_reg(RegWetMix, wet);
		write_reg(RegWetMix + CfgIdxW'($urandom_range(1, 3)), 17'($urandom));
		cfg_wen <= 1'b0;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// runs of similar level so the envelope climbs and decays across the gate threshold
	task automatic run_phase(input int count);
		int amp;
		amp = 0;
		for (int i = 0; i < count; i++) begin
			if (i % RunLength == 0) begin
				case ($urandom_range(0, 2))
					0: amp = $urandom_range(0, 64);
					1: amp = $urandom_range(0, 4096);
					default: amp = 32767;
				endcase
			end
			send_request(random_sample(amp), $urandom_range(0, 9) == 0);
		end
	endtask

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("[adaptive_ema_noise_gate] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = idle_cycles();
			if (rx_hold_req) begin
				gap = RxHoldCycles;
				rx_hold_req = 1'b0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = RegEnvCoef;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		steady = 1'b0;
		rx_hold_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full scale both ways, zero, missing input, envelope build-up
		send_request(16'h7fff, 1'b0);
		send_request(16'h8000, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'h8000, 1'b1);
		send_request(16'h0001, 1'b0);
		send_request(16'hffff, 1'b0);
		repeat (3) send_request(16'h7fff, 1'b0);
		repeat (2) send_request(16'h8000, 1'b0);
		settle();

		// inverted alpha range, gate always open, wet mix above unity
		apply_settings('1, '1, '0, '0, '1);
		send_request(16'h8000, 1'b0);
		send_request(16'h7fff, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'h7fff, 1'b1);
		send_request(16'h3039, 1'b0);
		settle();

		// frozen envelope, threshold above full scale, fully dry
		apply_settings('0, '0, '1, '1, '0);
		send_request(16'h7fff, 1'b0);
		send_request(16'h8000, 1'b0);
		send_request(16'h0000, 1'b1);
		send_request(16'h0064, 1'b0);
		settle();

		for (int p = 0; p < Phases; p++) begin
			apply_settings(pick_coef(), pick_coef(), pick_coef(), pick_threshold(), pick_wet());
			steady = (p == 1) || (p == 2);
			rx_hold_req = (p == 2);
			run_phase(PhaseItems);
			settle();
		end
		steady = 1'b0;
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("[adaptive_ema_noise_gate] OK");
		else
			$display("[adaptive_ema_noise_gate] ERROR");
		$finish;
	end

endmodule
